// File: hdl/lplt_pkg.sv
`default_nettype none
// ============================================================================
// lplt_pkg
// Types and constants shared by the length-prefixed loader and its checker.
// ============================================================================
package lplt_pkg;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_LEN_LO = 2'd1,
        PH_LEN_HI = 2'd2,
        PH_DATA   = 2'd3
    } t_phase;

    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_TICK  = 2'd1;
    localparam logic [1:0] MODE_BYTE  = 2'd2;

    localparam logic [1:0] ST_NONE    = 2'd0;
    localparam logic [1:0] ST_DONE    = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;
    localparam logic [1:0] ST_BADLEN  = 2'd3;

    localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd0;
    localparam logic [1:0] REG_MAX_LENGTH    = 2'd1;
    localparam logic [1:0] REG_BASE_ADDRESS  = 2'd2;

    localparam logic [15:0] RST_TIMEOUT_TICKS = 16'd300;
    localparam logic [15:0] RST_MAX_LENGTH    = 16'h7FF7;
    localparam logic [15:0] RST_BASE_ADDRESS  = 16'h4009;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] data_byte;
    } t_in;

    typedef struct packed {
        logic        write_valid;
        logic [15:0] write_address;
        logic [7:0]  write_data;
        logic [1:0]  status;
        logic        busy_res;
    } t_out;

endpackage
`default_nettype wire

// File: hdl/length_prefixed_loader_with_timeout.sv
`default_nettype none
// ============================================================================
// length_prefixed_loader_with_timeout
// Receives a length-prefixed load frame and turns payload bytes into writes.
// ============================================================================
// One transaction is taken per clock and each one yields exactly one result
// transaction in the next cycle, out of a single output register; the input
// side stalls only while that register is full and the output stalls. The
// frame state (phase, length, count, countdown) updates at acceptance, so
// consecutive items flow with no bubbles. Configuration writes are always
// ready and take effect on the next accepted item.
module length_prefixed_loader_with_timeout
    import lplt_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output      logic        o_in_stall,
    input  wire t_in         i_in_data,
    output      logic        o_out_valid,
    input  wire logic        i_out_stall,
    output      t_out        o_out_data,
    input  wire logic        i_cfg_valid,
    output      logic        o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    logic [15:0] r_timeout_ticks;
    logic [15:0] r_max_length;
    logic [15:0] r_base_address;

    t_phase      r_phase, n_phase;
    logic [15:0] r_expected, n_expected;
    logic [15:0] r_count, n_count;
    logic [15:0] r_countdown, n_countdown;

    logic        r_out_valid;
    t_out        r_out, n_out;

    logic        w_accept;
    logic [15:0] w_len_full;
    logic [15:0] w_count_inc;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_out_valid & i_out_stall;
    assign w_accept    = i_in_valid & ~o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_len_full  = {i_in_data.data_byte, r_expected[7:0]};
    assign w_count_inc = r_count + 16'd1;

    // next state
    always_comb begin
        n_phase = r_phase;
        case (i_in_data.mode)
            MODE_START: n_phase = PH_LEN_LO;
            MODE_TICK: begin
                if (r_phase != PH_IDLE && r_countdown <= 16'd1) begin
                    n_phase = PH_IDLE;
                end
            end
            MODE_BYTE: begin
                case (r_phase)
                    PH_LEN_LO: n_phase = PH_LEN_HI;
                    PH_LEN_HI: begin
                        if (w_len_full == 16'd0 || w_len_full > r_max_length) begin
                            n_phase = PH_IDLE;
                        end else begin
                            n_phase = PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        if (w_count_inc >= r_expected) begin
                            n_phase = PH_IDLE;
                        end
                    end
                    default: n_phase = r_phase;
                endcase
            end
            default: n_phase = r_phase;
        endcase
    end

    // datapath and result
    always_comb begin
        n_expected  = r_expected;
        n_count     = r_count;
        n_countdown = r_countdown;
        n_out       = '0;
        case (i_in_data.mode)
            MODE_START: n_countdown = r_timeout_ticks;
            MODE_TICK: begin
                if (r_phase != PH_IDLE) begin
                    if (r_countdown <= 16'd1) begin
                        n_countdown  = '0;
                        n_out.status = ST_TIMEOUT;
                    end else begin
                        n_countdown = r_countdown - 16'd1;
                    end
                end
            end
            MODE_BYTE: begin
                if (r_phase != PH_IDLE) begin
                    n_countdown = r_timeout_ticks;
                end
                case (r_phase)
                    PH_LEN_LO: begin
                        n_expected = {8'd0, i_in_data.data_byte};
                        n_count    = '0;
                    end
                    PH_LEN_HI: begin
                        n_expected = w_len_full;
                        if (w_len_full == 16'd0 || w_len_full > r_max_length) begin
                            n_out.status = ST_BADLEN;
                        end
                    end
                    PH_DATA: begin
                        n_out.write_valid   = 1'b1;
                        n_out.write_address = r_base_address + r_count;
                        n_out.write_data    = i_in_data.data_byte;
                        n_count             = w_count_inc;
                        if (w_count_inc >= r_expected) begin
                            n_out.status = ST_DONE;
                        end
                    end
                    default: n_count = r_count;
                endcase
            end
            default: n_count = r_count;
        endcase
        n_out.busy_res = (n_phase != PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_ticks <= RST_TIMEOUT_TICKS;
            r_max_length    <= RST_MAX_LENGTH;
            r_base_address  <= RST_BASE_ADDRESS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_TIMEOUT_TICKS: r_timeout_ticks <= i_cfg_data;
                REG_MAX_LENGTH:    r_max_length    <= i_cfg_data;
                REG_BASE_ADDRESS:  r_base_address  <= i_cfg_data;
                default:           r_base_address  <= r_base_address;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_expected  <= '0;
            r_count     <= '0;
            r_countdown <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_phase     <= n_phase;
                r_expected  <= n_expected;
                r_count     <= n_count;
                r_countdown <= n_countdown;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

endmodule
`default_nettype wire

// File: hdl/lplt_checker.sv
`default_nettype none
// ============================================================================
// lplt_checker
// Port-level checks for the length-prefixed loader.
// ============================================================================
module lplt_checker
    import lplt_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic o_in_stall,
    input wire logic o_out_valid,
    input wire logic i_out_stall,
    input wire t_out o_out_data
);

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(o_out_valid) && $past(i_out_stall)
        |-> o_out_valid && $stable(o_out_data))
        else $error("stalled result transaction changed");

    // no write means zero address and data
    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.write_valid
        |-> o_out_data.write_address == 16'd0 && o_out_data.write_data == 8'd0)
        else $error("address or data set without a write");

    // any final status ends the load
    a_status_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != ST_NONE |-> !o_out_data.busy_res)
        else $error("load still busy after completion or abort");

    // a write only comes with no status or completion
    a_write_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.write_valid
        |-> o_out_data.status == ST_NONE || o_out_data.status == ST_DONE)
        else $error("write paired with an abort status");

    // an accepted transaction shows a result on the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_out_valid)
        else $error("accepted transaction produced no result");

endmodule

bind length_prefixed_loader_with_timeout lplt_checker u_lplt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb
// Checks the length-prefixed loader against a cycle-free frame predictor.
// ============================================================================
// Directed frames cover idle ignores, the unused mode, restart, zero and
// oversize lengths and a complete load. Random frames then run under
// several register settings (timeout, max length, base address, extremes
// included), with random gaps on the sender and random stalls on the
// receiver. Every result transaction is compared field by field in order.
// ============================================================================
module tb;
    import lplt_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int QUIET_LIMIT = 2000;
    localparam int NUM_SETTINGS = 6;

    class frame_load_tracker;
        logic [15:0] timeout_ticks;
        logic [15:0] max_length;
        logic [15:0] base_address;
        t_phase      phase;
        logic [15:0] expected_length;
        logic [15:0] received_count;
        logic [15:0] countdown;
        t_out        pending_results[$];
        int          mismatches;
        int          completes;
        int          timeouts;
        int          bad_lengths;
        int          payload_writes;

        function new();
            timeout_ticks = RST_TIMEOUT_TICKS;
            max_length = RST_MAX_LENGTH;
            base_address = RST_BASE_ADDRESS;
            phase = PH_IDLE;
            expected_length = '0;
            received_count = '0;
            countdown = '0;
            mismatches = 0;
            completes = 0;
            timeouts = 0;
            bad_lengths = 0;
            payload_writes = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] val);
            case (idx)
                REG_TIMEOUT_TICKS: timeout_ticks = val;
                REG_MAX_LENGTH:    max_length = val;
                REG_BASE_ADDRESS:  base_address = val;
                default: ;
            endcase
        endfunction

        function t_out step_frame(t_in item);
            t_out res;
            res = '0;
            case (item.mode)
                MODE_START: begin
                    phase = PH_LEN_LO;
                    countdown = timeout_ticks;
                end
                MODE_TICK: begin
                    if (phase != PH_IDLE) begin
                        if (countdown <= 16'd1) begin
                            countdown = '0;
                            phase = PH_IDLE;
                            res.status = ST_TIMEOUT;
                            timeouts++;
                        end else begin
                            countdown = countdown - 16'd1;
                        end
                    end
                end
                MODE_BYTE: begin
                    if (phase != PH_IDLE) begin
                        countdown = timeout_ticks;
                        case (phase)
                            PH_LEN_LO: begin
                                expected_length = {8'h00, item.data_byte};
                                received_count = '0;
                                phase = PH_LEN_HI;
                            end
                            PH_LEN_HI: begin
                                expected_length = expected_length | {item.data_byte, 8'h00};
                                if (expected_length == 16'd0 || expected_length > max_length) begin
                                    phase = PH_IDLE;
                                    res.status = ST_BADLEN;
                                    bad_lengths++;
                                end else begin
                                    phase = PH_DATA;
                                end
                            end
                            default: begin
                                res.write_valid = 1'b1;
                                res.write_address = base_address + received_count;
                                res.write_data = item.data_byte;
                                received_count = received_count + 16'd1;
                                payload_writes++;
                                if (received_count >= expected_length) begin
                                    phase = PH_IDLE;
                                    res.status = ST_DONE;
                                    completes++;
                                end
                            end
                        endcase
                    end
                end
                default: ;
            endcase
            res.busy_res = (phase != PH_IDLE);
            return res;
        endfunction

        // returns 1 when the transaction can change the frame state
        function bit note_input(t_in item);
            bit effective;
            effective = (item.mode == MODE_START)
                || (phase != PH_IDLE && item.mode != MODE_UNUSED);
            pending_results.push_back(step_frame(item));
            return effective;
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: %p", got);
                return;
            end
            want = pending_results.pop_front();
            if (got.write_valid !== want.write_valid
                    || got.write_address !== want.write_address
                    || got.write_data !== want.write_data
                    || got.status !== want.status
                    || got.busy_res !== want.busy_res) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result mismatch: expected wv=%0b addr=%h data=%h st=%0d busy=%0b",
                             want.write_valid, want.write_address, want.write_data,
                             want.status, want.busy_res);
                    $display("                 got      wv=%0b addr=%h data=%h st=%0d busy=%0b",
                             got.write_valid, got.write_address, got.write_data,
                             got.status, got.busy_res);
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    t_in         in_data = '0;
    logic        in_stall;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out        out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_TIMEOUT_TICKS;
    logic [15:0] cfg_data = '0;

    frame_load_tracker tracker;
    bit steady = 1'b0;
    int effective_items = 0;
    int stall_left = 0;
    int quiet_cycles = 0;

    t_in opening_items [25] = '{
        '{MODE_TICK, 8'hFF}, '{MODE_BYTE, 8'hAA}, '{MODE_UNUSED, 8'h55},
        '{MODE_START, 8'h00}, '{MODE_BYTE, 8'h02}, '{MODE_BYTE, 8'h00},
        '{MODE_UNUSED, 8'hFF}, '{MODE_TICK, 8'h00}, '{MODE_BYTE, 8'h00},
        '{MODE_BYTE, 8'hFF},
        '{MODE_START, 8'hFF}, '{MODE_BYTE, 8'h00}, '{MODE_BYTE, 8'h00},
        '{MODE_START, 8'h00}, '{MODE_BYTE, 8'hF8}, '{MODE_BYTE, 8'h7F},
        '{MODE_START, 8'h00}, '{MODE_BYTE, 8'h33}, '{MODE_START, 8'h00},
        '{MODE_BYTE, 8'h01}, '{MODE_BYTE, 8'h00}, '{MODE_BYTE, 8'h5A},
        '{MODE_START, 8'h00}, '{MODE_BYTE, 8'hF7}, '{MODE_BYTE, 8'h7F}
    };

    logic [15:0] set_timeout [NUM_SETTINGS] = '{16'd0, 16'd1, 16'd3, 16'hFFFF, 16'd2,
                                                 RST_TIMEOUT_TICKS};
    logic [15:0] set_max_len [NUM_SETTINGS] = '{16'd1, 16'hFFFF, 16'd5, 16'd300, 16'd1,
                                                 RST_MAX_LENGTH};
    logic [15:0] set_base [NUM_SETTINGS] = '{16'hFFFF, 16'h0000, 16'hFFFE, 16'h1234,
                                              16'h0000, RST_BASE_ADDRESS};

    length_prefixed_loader_with_timeout dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic send_item(input logic [1:0] mode, input logic [7:0] value);
        t_in item;
        int r;
        int n;
        item.mode = mode;
        item.data_byte = value;
        n = 0;
        if (!steady) begin
            r = $urandom_range(0, 99);
            if (r >= 95)
                n = $urandom_range(10, 40);
            else if (r >= 65)
                n = $urandom_range(1, 3);
        end
        if (n > 0) begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        do @(posedge clk); while (in_stall);
        if (tracker.note_input(item))
            effective_items++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (tracker.pending_results.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // ticks and unused-mode transactions slipped in between frame bytes
    task automatic interleave_noise();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
            repeat ($urandom_range(1, 2)) send_item(MODE_TICK, 8'($urandom));
        else if (r < 23)
            send_item(MODE_UNUSED, 8'($urandom));
    endtask

    task automatic run_frame();
        int kind;
        int len;
        int lim;
        int n;
        logic [15:0] bad;
        kind = $urandom_range(0, 99);
        if (kind < 65) begin
            lim = (tracker.max_length > 16'd8) ? 8 : int'(tracker.max_length);
            len = $urandom_range(1, lim);
            if ($urandom_range(0, 3) == 0 && tracker.max_length <= 16'd40)
                len = int'(tracker.max_length);
            send_item(MODE_START, 8'($urandom));
            send_item(MODE_BYTE, len[7:0]);
            interleave_noise();
            send_item(MODE_BYTE, len[15:8]);
            for (int i = 0; i < len; i++) begin
                interleave_noise();
                send_item(MODE_BYTE, 8'($urandom));
            end
        end else if (kind < 77) begin
            n = $urandom_range(0, 2);
            if (n == 0 || tracker.max_length == 16'hFFFF)
                bad = 16'd0;
            else if (n == 1)
                bad = tracker.max_length + 16'd1;
            else
                bad = 16'($urandom_range(int'(tracker.max_length) + 1, 65535));
            send_item(MODE_START, 8'($urandom));
            send_item(MODE_BYTE, bad[7:0]);
            send_item(MODE_BYTE, bad[15:8]);
        end else if (kind < 87) begin
            send_item(MODE_START, 8'($urandom));
            repeat ($urandom_range(0, 2)) send_item(MODE_BYTE, 8'($urandom));
            n = (tracker.timeout_ticks <= 16'd40) ? int'(tracker.timeout_ticks) + 1
                                                  : $urandom_range(1, 5);
            repeat (n) send_item(MODE_TICK, 8'($urandom));
        end else begin
            repeat ($urandom_range(1, 6))
                send_item(2'($urandom_range(0, 3)), 8'($urandom));
        end
    endtask

    // result side: checks accepted results and stalls at random
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall)
                tracker.check_result(out_data);
            if (stall_left > 0)
                stall_left--;
            else if (!steady && $urandom_range(0, 99) < 25)
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                          : $urandom_range(1, 3);
            out_stall <= (stall_left != 0);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: %0d cycles without a transaction", quiet_cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int stop;
        logic [1:0]  reg_idx [3];
        logic [15:0] reg_val [3];
        tracker = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening_items[i])
            send_item(opening_items[i].mode, opening_items[i].data_byte);

        for (int p = 0; p < NUM_SETTINGS; p++) begin
            reg_idx = '{REG_TIMEOUT_TICKS, REG_MAX_LENGTH, REG_BASE_ADDRESS};
            reg_val = '{set_timeout[p], set_max_len[p], set_base[p]};
            if (p == 4)
                reg_val = '{16'($urandom_range(2, 12)), 16'($urandom_range(1, 40)),
                            16'($urandom)};
            wait_drained();
            cfg_valid <= 1'b1;
            foreach (reg_idx[i]) begin
                cfg_index <= reg_idx[i];
                cfg_data <= reg_val[i];
                do @(posedge clk); while (!cfg_ready);
                tracker.set_reg(reg_idx[i], reg_val[i]);
            end
            cfg_valid <= 1'b0;

            stop = effective_items + 55;
            while (effective_items < stop) begin
                if ($urandom_range(0, 9) == 0)
                    steady = !steady;
                if ($urandom_range(0, 29) == 0)
                    wait_drained();
                run_frame();
            end
            steady = 1'b0;
        end

        wait_drained();
        repeat (5) @(posedge clk);
        $display("run covered %0d frame transactions over %0d register settings",
                 effective_items, NUM_SETTINGS + 1);
        $display("%0d payload writes, %0d loads done, %0d timeouts, %0d bad lengths",
                 tracker.payload_writes, tracker.completes, tracker.timeouts,
                 tracker.bad_lengths);
        if (tracker.mismatches == 0 && tracker.pending_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

// File: files.f
hdl/lplt_pkg.sv
hdl/length_prefixed_loader_with_timeout.sv
hdl/lplt_checker.sv
verif/tb.sv
